[hdl/air_density_from_altitude_macros.svh]
// assertion macros for the air density block
// no dependencies; clock clk and reset rst_n are taken from the including scope
`ifndef AIR_DENSITY_FROM_ALTITUDE_MACROS_SVH
`define AIR_DENSITY_FROM_ALTITUDE_MACROS_SVH

// same-cycle implication
`define ADFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adfa check failed");

// next-cycle implication
`define ADFA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adfa check failed");

`endif

[hdl/adfa_pkg.sv]
// shared types and constants for the air density block
// no dependencies
package adfa_pkg;

    localparam int N_ENT  = 61;
    localparam int IDX_W  = 6;
    localparam int ALT_W  = 20;
    localparam int T_W    = 24;
    localparam int DEN_W  = 46;
    localparam int PQ_W   = 27;

    localparam logic [T_W-1:0]   T_BASE    = 24'd9220800;
    localparam logic [T_W-1:0]   T_SLOPE   = 24'd13;
    localparam logic [21:0]      DEN_CONST = 22'd3464357;
    localparam logic [35:0]      NUM_CONST = 36'd38619200000;
    localparam logic [16:0]      DENS_MAX  = 17'd131071;

    typedef enum logic [0:0] {REG_LAUNCH_ALT = 1'b0} adfa_reg_t;

    // breakpoint altitudes in metres
    localparam logic [13:0] ALT_M [0:N_ENT-1] = '{
        14'd0, 14'd152, 14'd305, 14'd457, 14'd610, 14'd762, 14'd914, 14'd1067,
        14'd1219, 14'd1372, 14'd1524, 14'd1676, 14'd1829, 14'd1981, 14'd2134,
        14'd2286, 14'd2438, 14'd2591, 14'd2743, 14'd2896, 14'd3048, 14'd3200,
        14'd3353, 14'd3505, 14'd3658, 14'd3810, 14'd3962, 14'd4115, 14'd4267,
        14'd4420, 14'd4572, 14'd4724, 14'd4877, 14'd5029, 14'd5182, 14'd5334,
        14'd5486, 14'd5639, 14'd5791, 14'd5944, 14'd6096, 14'd6248, 14'd6401,
        14'd6553, 14'd6706, 14'd6858, 14'd7010, 14'd7163, 14'd7315, 14'd7468,
        14'd7620, 14'd7772, 14'd7925, 14'd8077, 14'd8230, 14'd8382, 14'd8534,
        14'd8687, 14'd8839, 14'd8992, 14'd9144
    };

    // pressures in tenths of a kilopascal
    localparam logic [9:0] PRESS [0:N_ENT-1] = '{
        10'd1013, 10'd994, 10'd976, 10'd958, 10'd941, 10'd924, 10'd907, 10'd891,
        10'd874, 10'd858, 10'd843, 10'd827, 10'd811, 10'd796, 10'd781, 10'd767,
        10'd752, 10'd738, 10'd723, 10'd710, 10'd696, 10'd683, 10'd670, 10'd657,
        10'd644, 10'd631, 10'd619, 10'd607, 10'd595, 10'd583, 10'd571, 10'd560,
        10'd548, 10'd538, 10'd527, 10'd515, 10'd506, 10'd495, 10'd486, 10'd475,
        10'd466, 10'd456, 10'd446, 10'd437, 10'd428, 10'd419, 10'd410, 10'd401,
        10'd393, 10'd384, 10'd376, 10'd368, 10'd360, 10'd352, 10'd345, 10'd337,
        10'd329, 10'd322, 10'd315, 10'd308, 10'd301
    };

    // classified word handed from front to back
    typedef struct packed {
        logic [ALT_W-1:0] alt16;
        logic [N_ENT-3:0] above;   // above[j]: altitude beyond breakpoint j+1
        logic             clamped;
    } adfa_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } adfa_fifo_st_t;

endpackage

[hdl/adfa_ifs.sv]
// channel interfaces of the air density block
// no dependencies
interface adfa_in_if;
    logic        valid;
    logic        ready;
    logic [17:0] height_above_launch;
    modport source (output valid, output height_above_launch, input ready);
    modport sink (input valid, input height_above_launch, output ready);
endinterface

interface adfa_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] air_density;
    logic        pressure_clamped;
    modport source (output valid, output air_density, output pressure_clamped, input ready);
    modport sink (input valid, input air_density, input pressure_clamped, output ready);
endinterface

[hdl/air_density_from_altitude.sv]
// top level of the air density block: register port, front, queue and back
// depends on adfa_pkg, adfa_ifs, adfa_front, adfa_fifo, adfa_back, macros header
//
// Takes one height word per clock and returns one density word per clock in the
// same order while the output is not stalled. The path runs through the
// two pipelined restoring dividers (27 stages for pressure interpolation,
// 18 for density), plus front, lookup and rounding stages. A four-word queue
// sits between the front and the pipeline, so the input keeps flowing until
// the queue is full while the output is stalled. launch_altitude is written over the
// register port at byte address 0 and should only change while the block is idle.
`include "air_density_from_altitude_macros.svh"

module air_density_from_altitude (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    adfa_in_if.sink     in_ch,
    adfa_out_if.source  out_ch
);

    logic [13:0]             launch_reg;
    logic                    wr_launch;
    logic                    push;
    logic                    pop;
    adfa_pkg::adfa_job_t     f_job;
    adfa_pkg::adfa_job_t     q_job;
    adfa_pkg::adfa_fifo_st_t fifo_st;

    assign pready    = 1'b1;
    assign wr_launch = psel && penable && pwrite && (paddr[2] == adfa_pkg::REG_LAUNCH_ALT);

    always_comb
    begin
        if (paddr[2] == adfa_pkg::REG_LAUNCH_ALT)
        begin
            prdata = {18'h00000, launch_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= '0;
        end
        else if (wr_launch)
        begin
            launch_reg <= pwdata[13:0];
        end
    end

    adfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch_alt (launch_reg),
        .in_ch      (in_ch),
        .fifo_st    (fifo_st),
        .push       (push),
        .job        (f_job)
    );

    adfa_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (f_job),
        .pop    (pop),
        .rd_job (q_job),
        .st     (fifo_st)
    );

    adfa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (q_job),
        .fifo_st (fifo_st),
        .pop     (pop),
        .out_ch  (out_ch)
    );

    // a register write lands in the next cycle
    `ADFA_ASSERT_NXT(a_cfg_write, wr_launch, launch_reg == $past(pwdata[13:0]))
    // input is refused only when the queue is full
    `ADFA_ASSERT_NOW(a_in_backpressure, !in_ch.ready, fifo_st.full)
    // an output stall holds the queue
    `ADFA_ASSERT_NOW(a_stall_no_pop, out_ch.valid && !out_ch.ready, !pop)

endmodule

[hdl/adfa_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on nothing
module adfa_div #(
    parameter int NW = 38,
    parameter int DW = 12,
    parameter int QW = 27,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          v_reg    [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] dvs_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] dvs_in;
        logic [SW-1:0] side_in_k;
        logic [DW:0]   trial;
        logic          qbit;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign v_in      = in_valid;
            assign rem_in    = DW'(dividend[NW-1:QW]);
            assign low_in    = dividend[QW-1:0];
            assign q_in      = '0;
            assign dvs_in    = divisor;
            assign side_in_k = side_in;
        end else begin : g_rest
            assign v_in      = v_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign low_in    = low_reg[k-1];
            assign q_in      = q_reg[k-1];
            assign dvs_in    = dvs_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, low_in[QW-1]};
            qbit  = (trial >= {1'b0, dvs_in});
            if (qbit)
            begin
                rem_next = DW'(trial - {1'b0, dvs_in});
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= {low_in[QW-2:0], 1'b0};
                q_reg[k]    <= {q_in[QW-2:0], qbit};
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quotient  = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

[hdl/adfa_front.sv]
// front stage: forms the sea-level altitude and classifies it against the breakpoints
// depends on adfa_pkg
module adfa_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [13:0]           launch_alt,
    adfa_in_if.sink               in_ch,
    input  adfa_pkg::adfa_fifo_st_t fifo_st,
    output logic                  push,
    output adfa_pkg::adfa_job_t   job
);

    logic                f_valid_reg;
    adfa_pkg::adfa_job_t f_job_reg;
    adfa_pkg::adfa_job_t job_next;
    logic                take;

    always_comb
    begin
        job_next.alt16 = {2'b00, launch_alt, 4'b0000} + 20'(in_ch.height_above_launch);
        for (int j = 0; j < adfa_pkg::N_ENT - 2; j++)
        begin
            job_next.above[j] = job_next.alt16 > {2'b00, adfa_pkg::ALT_M[j+1], 4'b0000};
        end
        job_next.clamped = job_next.alt16 >
                           {2'b00, adfa_pkg::ALT_M[adfa_pkg::N_ENT-1], 4'b0000};
    end

    assign push        = f_valid_reg && !fifo_st.full;
    assign in_ch.ready = !f_valid_reg || !fifo_st.full;
    assign take        = in_ch.valid && in_ch.ready;
    assign job         = f_job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_job_reg <= job_next;
        end
    end

endmodule

[hdl/adfa_fifo.sv]
// four-word queue between front and back
// depends on adfa_pkg
module adfa_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  adfa_pkg::adfa_job_t     wr_job,
    input  logic                    pop,
    output adfa_pkg::adfa_job_t     rd_job,
    output adfa_pkg::adfa_fifo_st_t st
);

    adfa_pkg::adfa_job_t mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign st.full  = (cnt_reg == 3'd4);
    assign st.empty = (cnt_reg == 3'd0);
    assign do_push  = push && !st.full;
    assign do_pop   = pop && !st.empty;
    assign rd_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[hdl/adfa_back.sv]
// back pipeline: table lookup, interpolation, temperature and the two dividers
// depends on adfa_pkg, adfa_div
module adfa_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  adfa_pkg::adfa_job_t     job,
    input  adfa_pkg::adfa_fifo_st_t fifo_st,
    output logic                    pop,
    adfa_out_if.source              out_ch
);

    localparam int D1_NW = 38;
    localparam int D2_NW = 63;
    localparam int Q2_W  = 18;

    logic en;

    // stage 1: segment index and temperature
    logic                        v1_reg;
    logic [adfa_pkg::IDX_W-1:0]  idx1_reg, idx1_next;
    logic [adfa_pkg::ALT_W-1:0]  alt1_reg;
    logic                        clamp1_reg;
    logic [adfa_pkg::T_W-1:0]    t1_reg, t1_next;

    // stage 2: segment entries and denominator
    logic                        v2_reg;
    logic [9:0]                  p0_reg, p0_next, p1_reg, p1_next;
    logic [11:0]                 dx_reg, dx_next, d_reg, d_next;
    logic                        clamp2_reg;
    logic [adfa_pkg::DEN_W-1:0]  den2_reg, den2_next;

    // stage 3: interpolation numerator
    logic                        v3_reg;
    logic [D1_NW-1:0]            dvd1_reg, dvd1_next;
    logic [11:0]                 dx3_reg;
    logic [adfa_pkg::DEN_W:0]    side3_reg;

    logic                        v_d1;
    logic [adfa_pkg::PQ_W-1:0]   pq_d1;
    logic [adfa_pkg::DEN_W:0]    side_d1;

    // stage 4: partial products of pressure times the constant numerator
    logic                        v4_reg;
    logic [44:0]                 pph_reg, pph_next, ppl_reg, ppl_next;
    logic [adfa_pkg::DEN_W:0]    side4_reg;

    // stage 5: rounded dividend
    logic                        v5_reg;
    logic [D2_NW-1:0]            dvd2_reg, dvd2_next;
    logic [adfa_pkg::DEN_W-1:0]  den5_reg;
    logic                        clamp5_reg;

    logic                        v_d2;
    logic [Q2_W-1:0]             q_d2;
    logic                        clamp_d2;

    logic                        ov_reg;
    logic [16:0]                 dens_reg, dens_next;
    logic                        oclamp_reg;

    logic [adfa_pkg::ALT_W-1:0]  x0, x1;

    assign en  = !ov_reg || out_ch.ready;
    assign pop = en && !fifo_st.empty;

    always_comb
    begin
        idx1_next = adfa_pkg::IDX_W'($countones(job.above));
        t1_next   = adfa_pkg::T_BASE - 24'(job.alt16) * adfa_pkg::T_SLOPE;
    end

    always_comb
    begin
        x0 = {2'b00, adfa_pkg::ALT_M[idx1_reg], 4'b0000};
        x1 = {2'b00, adfa_pkg::ALT_M[idx1_reg + 6'd1], 4'b0000};
        dx_next = 12'(x1 - x0);
        if (clamp1_reg)
        begin
            p0_next = adfa_pkg::PRESS[adfa_pkg::N_ENT-1];
            p1_next = adfa_pkg::PRESS[adfa_pkg::N_ENT-1];
            d_next  = '0;
        end
        else
        begin
            p0_next = adfa_pkg::PRESS[idx1_reg];
            p1_next = adfa_pkg::PRESS[idx1_reg + 6'd1];
            d_next  = 12'(alt1_reg - x0);
        end
        den2_next = 46'(t1_reg) * 46'(adfa_pkg::DEN_CONST);
    end

    always_comb
    begin
        logic [21:0] num;
        num = 22'(p0_reg) * 22'(dx_reg) - 22'(p0_reg - p1_reg) * 22'(d_reg);
        dvd1_next = {num, 16'h0000} + 38'(dx_reg >> 1);
    end

    adfa_div #(.NW(D1_NW), .DW(12), .QW(adfa_pkg::PQ_W), .SW(adfa_pkg::DEN_W + 1)) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .dividend  (dvd1_reg),
        .divisor   (dx3_reg),
        .side_in   (side3_reg),
        .out_valid (v_d1),
        .quotient  (pq_d1),
        .side_out  (side_d1)
    );

    always_comb
    begin
        pph_next = 45'(pq_d1) * 45'(adfa_pkg::NUM_CONST[35:18]);
        ppl_next = 45'(pq_d1) * 45'(adfa_pkg::NUM_CONST[17:0]);
    end

    always_comb
    begin
        dvd2_next = {pph_reg, 18'h00000} + 63'(ppl_reg)
                    + 63'(side4_reg[adfa_pkg::DEN_W-1:0] >> 1);
    end

    adfa_div #(.NW(D2_NW), .DW(adfa_pkg::DEN_W), .QW(Q2_W), .SW(1)) u_div_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .dividend  (dvd2_reg),
        .divisor   (den5_reg),
        .side_in   (clamp5_reg),
        .out_valid (v_d2),
        .quotient  (q_d2),
        .side_out  (clamp_d2)
    );

    // saturate to the field maximum
    always_comb
    begin
        if (q_d2 > 18'(adfa_pkg::DENS_MAX))
        begin
            dens_next = adfa_pkg::DENS_MAX;
        end
        else
        begin
            dens_next = q_d2[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !fifo_st.empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v_d1;
            v5_reg <= v4_reg;
            ov_reg <= v_d2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg   <= idx1_next;
            alt1_reg   <= job.alt16;
            clamp1_reg <= job.clamped;
            t1_reg     <= t1_next;
            p0_reg     <= p0_next;
            p1_reg     <= p1_next;
            dx_reg     <= dx_next;
            d_reg      <= d_next;
            clamp2_reg <= clamp1_reg;
            den2_reg   <= den2_next;
            dvd1_reg   <= dvd1_next;
            dx3_reg    <= dx_reg;
            side3_reg  <= {clamp2_reg, den2_reg};
            pph_reg    <= pph_next;
            ppl_reg    <= ppl_next;
            side4_reg  <= side_d1;
            dvd2_reg   <= dvd2_next;
            den5_reg   <= side4_reg[adfa_pkg::DEN_W-1:0];
            clamp5_reg <= side4_reg[adfa_pkg::DEN_W];
            dens_reg   <= dens_next;
            oclamp_reg <= clamp_d2;
        end
    end

    assign out_ch.valid            = ov_reg;
    assign out_ch.air_density      = dens_reg;
    assign out_ch.pressure_clamped = oclamp_reg;

endmodule
